FILE: rtl/core/assert_macros.svh
// assertion macros shared by the normaliser rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked property, suspended while reset is high
`define B32N_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// checked property that also holds during reset
`define B32N_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/core/b32n_pkg.sv
// types and constants of the base32 code normaliser
package b32n_pkg;

   // number of kept symbols that make a complete code
   localparam int CODE_LENGTH = 8;
   localparam int SYMBOL_W    = 8;
   localparam int CODE_W      = 64;
   localparam int CNT_W       = $clog2(CODE_LENGTH + 1);

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // ascii codes
   localparam logic [7:0] CHAR_NUL    = 8'h00;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_DASH   = 8'h2D;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_ONE    = 8'h31;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_UP_A   = 8'h41;
   localparam logic [7:0] CHAR_UP_I   = 8'h49;
   localparam logic [7:0] CHAR_UP_L   = 8'h4C;
   localparam logic [7:0] CHAR_UP_O   = 8'h4F;
   localparam logic [7:0] CHAR_UP_U   = 8'h55;
   localparam logic [7:0] CHAR_UP_Z   = 8'h5A;
   localparam logic [7:0] CHAR_LO_A   = 8'h61;
   localparam logic [7:0] CHAR_LO_Z   = 8'h7A;
   localparam logic [7:0] CASE_OFFSET = 8'd32;

   // class of one incoming item
   typedef enum logic [1:0] {
      KIND_DROP,
      KIND_SYMBOL,
      KIND_REFUSE,
      KIND_TERM
   } kind_type;

   // classified item carried from front to back
   typedef struct packed {
      kind_type              kind;
      logic [SYMBOL_W-1:0]   symbol;
   } entry_type;

endpackage

FILE: rtl/core/b32n_chan_if.sv
// valid/ready channels of the base32 code normaliser
interface b32n_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] typed_byte;

   modport source (output valid, output typed_byte, input ready);
   modport sink   (input valid, input typed_byte, output ready);
endinterface

interface b32n_rsp_if;
   logic        valid;
   logic        ready;
   logic        accepted;
   logic [63:0] code_symbols;

   modport source (output valid, output accepted, output code_symbols, input ready);
   modport sink   (input valid, input accepted, input code_symbols, output ready);
endinterface

FILE: rtl/core/b32n_front.sv
// front end: accepts typed bytes, folds and classifies them
module b32n_front (
   b32n_req_if.sink              req_ch,
   input  logic                  push_ready,
   output logic                  push,
   output b32n_pkg::entry_type   push_entry
);

   logic [7:0] upper;
   logic       is_sep;

   // fold lower case and spot separators
   always_comb begin
      upper  = req_ch.typed_byte;
      if (req_ch.typed_byte inside {[b32n_pkg::CHAR_LO_A:b32n_pkg::CHAR_LO_Z]}) begin
         upper = req_ch.typed_byte - b32n_pkg::CASE_OFFSET;
      end
      is_sep = req_ch.typed_byte inside {b32n_pkg::CHAR_DASH, b32n_pkg::CHAR_SPACE,
                                         b32n_pkg::CHAR_TAB, b32n_pkg::CHAR_CR,
                                         b32n_pkg::CHAR_LF};
   end

   // classify the item and map look-alike letters onto digits
   always_comb begin
      push_entry.kind   = b32n_pkg::KIND_REFUSE;
      push_entry.symbol = upper;
      if (req_ch.typed_byte == b32n_pkg::CHAR_NUL) begin
         push_entry.kind = b32n_pkg::KIND_TERM;
      end else if (is_sep) begin
         push_entry.kind = b32n_pkg::KIND_DROP;
      end else if (upper == b32n_pkg::CHAR_UP_O) begin
         push_entry.kind   = b32n_pkg::KIND_SYMBOL;
         push_entry.symbol = b32n_pkg::CHAR_ZERO;
      end else if (upper == b32n_pkg::CHAR_UP_I || upper == b32n_pkg::CHAR_UP_L) begin
         push_entry.kind   = b32n_pkg::KIND_SYMBOL;
         push_entry.symbol = b32n_pkg::CHAR_ONE;
      end else if ((upper inside {[b32n_pkg::CHAR_ZERO:b32n_pkg::CHAR_NINE],
                                  [b32n_pkg::CHAR_UP_A:b32n_pkg::CHAR_UP_Z]})
                   && upper != b32n_pkg::CHAR_UP_U) begin
         push_entry.kind = b32n_pkg::KIND_SYMBOL;
      end
   end

   // separators are accepted but never queued
   assign req_ch.ready = push_ready;
   assign push         = req_ch.valid && push_ready
                         && (push_entry.kind != b32n_pkg::KIND_DROP);

endmodule

FILE: rtl/core/b32n_queue.sv
// short queue of classified items between front and back
module b32n_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  b32n_pkg::entry_type   push_entry,
   output logic                  push_ready,
   output logic                  pop_valid,
   output b32n_pkg::entry_type   pop_entry,
   input  logic                  pop
);

`include "assert_macros.svh"

   b32n_pkg::entry_type                 slot_ff [b32n_pkg::QUEUE_DEPTH];
   logic [b32n_pkg::QPTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [b32n_pkg::QPTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [b32n_pkg::QCNT_W-1:0]         count_ff, count_in;

   assign push_ready = (count_ff != b32n_pkg::QCNT_W'(b32n_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = slot_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == b32n_pkg::QPTR_W'(b32n_pkg::QUEUE_DEPTH - 1))
                     ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == b32n_pkg::QPTR_W'(b32n_pkg::QUEUE_DEPTH - 1))
                     ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // slot storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `B32N_ASSERT(a_no_push_full, clock, reset, push |-> push_ready, "push into full queue")
   `B32N_ASSERT(a_no_pop_empty, clock, reset, pop |-> pop_valid, "pop from empty queue")
   `B32N_ASSERT(a_count_bound, clock, reset,
      count_ff <= b32n_pkg::QCNT_W'(b32n_pkg::QUEUE_DEPTH), "queue count out of range")

endmodule

FILE: rtl/core/b32n_back.sv
// back end: collects symbols and forms the result item at the terminator
module b32n_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  pop_valid,
   input  b32n_pkg::entry_type   pop_entry,
   output logic                  pop,
   b32n_rsp_if.source            rsp_ch
);

`include "assert_macros.svh"

   logic [b32n_pkg::SYMBOL_W-1:0] buf_ff [b32n_pkg::CODE_LENGTH];
   logic [b32n_pkg::CNT_W-1:0]    count_ff, count_in;
   logic                          refused_ff, refused_in;
   logic                          out_valid_ff, out_valid_in;
   logic                          accepted_ff, accepted_in;
   logic [b32n_pkg::CODE_W-1:0]   symbols_ff, symbols_in;
   logic                          store;
   logic                          full;
   logic                          is_term;
   logic                          ok;
   logic [b32n_pkg::CODE_W-1:0]   packed_code;

   assign full    = (count_ff == b32n_pkg::CNT_W'(b32n_pkg::CODE_LENGTH));
   assign is_term = (pop_entry.kind == b32n_pkg::KIND_TERM);
   assign ok      = !refused_ff && full;

   // a terminator waits only for room in the output register
   assign pop = pop_valid && (!is_term || !out_valid_ff || rsp_ch.ready);

   // pack kept symbols, first symbol in the highest used byte
   always_comb begin
      packed_code = '0;
      for (int i = 0; i < b32n_pkg::CODE_LENGTH; i++) begin
         packed_code[(b32n_pkg::CODE_LENGTH - 1 - i) * b32n_pkg::SYMBOL_W +: b32n_pkg::SYMBOL_W]
            = buf_ff[i];
      end
   end

   // symbol count, refusal and result update
   always_comb begin
      count_in     = count_ff;
      refused_in   = refused_ff;
      store        = 1'b0;
      out_valid_in = out_valid_ff && !rsp_ch.ready;
      accepted_in  = accepted_ff;
      symbols_in   = symbols_ff;
      if (pop) begin
         case (pop_entry.kind)
            b32n_pkg::KIND_TERM: begin
               out_valid_in = 1'b1;
               accepted_in  = ok;
               symbols_in   = ok ? packed_code : '0;
               count_in     = '0;
               refused_in   = 1'b0;
            end
            b32n_pkg::KIND_REFUSE: begin
               refused_in = 1'b1;
            end
            b32n_pkg::KIND_SYMBOL: begin
               if (!refused_ff) begin
                  if (full) begin
                     refused_in = 1'b1;
                  end else begin
                     store    = 1'b1;
                     count_in = count_ff + 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         refused_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         refused_ff   <= refused_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // symbol buffer and result payload
   always_ff @(posedge clock) begin
      accepted_ff <= accepted_in;
      symbols_ff  <= symbols_in;
      for (int i = 0; i < b32n_pkg::CODE_LENGTH; i++) begin
         if (store && count_ff == b32n_pkg::CNT_W'(i)) begin
            buf_ff[i] <= pop_entry.symbol;
         end
      end
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.accepted     = accepted_ff;
   assign rsp_ch.code_symbols = symbols_ff;

   `B32N_ASSERT(a_count_bound, clock, reset,
      count_ff <= b32n_pkg::CNT_W'(b32n_pkg::CODE_LENGTH), "symbol count past code length")
   `B32N_ASSERT(a_term_restart, clock, reset,
      (pop && is_term) |=> (out_valid_ff && count_ff == '0 && !refused_ff),
      "terminator did not restart the string")
   `B32N_ASSERT(a_refused_zero, clock, reset,
      (out_valid_ff && !accepted_ff) |-> (symbols_ff == '0), "refused code not zero")

endmodule

FILE: rtl/core/base32_code_normaliser_top.sv
// top level of the base32 code normaliser
// Takes one typed byte per cycle while the queue has room and normalises it to a
// Crockford base32 code: separators are dropped, lower case is folded, O maps to 0
// and I or L to 1, and any other byte outside the alphabet or a ninth kept symbol
// refuses the string. A zero byte ends the string and gives one result item
// (accepted and the eight packed symbols, or zero), registered in the output
// register when the back takes the terminator from the queue. Sustained rate is
// one byte per cycle: the front classifies a byte in the cycle it is taken, a
// two-entry queue decouples it from the back, and the back updates its symbol
// buffer. Only a result item left waiting at the output stalls the back, and
// input is held off once the queue fills.
module base32_code_normaliser_top (
   input  logic        clock,
   input  logic        reset,
   b32n_req_if.sink    req_ch,
   b32n_rsp_if.source  rsp_ch
);

   logic                 push;
   logic                 push_ready;
   b32n_pkg::entry_type  push_entry;
   logic                 pop_valid;
   logic                 pop;
   b32n_pkg::entry_type  pop_entry;

   // classify incoming bytes
   b32n_front u_front (
      .req_ch     (req_ch),
      .push_ready (push_ready),
      .push       (push),
      .push_entry (push_entry)
   );

   // decouple front and back
   b32n_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry),
      .pop        (pop)
   );

   // collect symbols and form the result
   b32n_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_entry (pop_entry),
      .pop       (pop),
      .rsp_ch    (rsp_ch)
   );

endmodule

FILE: sim/b32n_code_checker.sv
// checker that predicts and compares the codes of the base32 code normaliser
module b32n_code_checker
   import b32n_pkg::*;
(
   input  logic clock,
   input  logic reset,
   b32n_req_if  req_ch,
   b32n_rsp_if  rsp_ch,
   output int   fail_count,
   output int   pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic              accepted;
      logic [CODE_W-1:0] code;
   } code_result_type;

   // predicted state of the normaliser
   logic [SYMBOL_W-1:0] kept_symbols [CODE_LENGTH];
   int                  kept_count;
   logic                refused;
   code_result_type     code_expect_q [$];

   // print one line and count
   task automatic report_mismatch(input string what, input logic [CODE_W-1:0] got,
                                  input logic [CODE_W-1:0] want);
      $display("%0t: %s: got %h, expected %h", $realtime, what, got, want);
      fail_count++;
   endtask

   // classify one typed byte and fold it to its symbol
   function automatic kind_type classify_byte(input logic [7:0] raw,
                                              output logic [7:0] folded);
      logic [7:0] up;
      up = raw;
      if (raw >= CHAR_LO_A && raw <= CHAR_LO_Z) up = raw - CASE_OFFSET;
      folded = up;
      if (raw == CHAR_NUL) return KIND_TERM;
      if (raw inside {CHAR_DASH, CHAR_SPACE, CHAR_TAB, CHAR_CR, CHAR_LF}) return KIND_DROP;
      if (up == CHAR_UP_O) begin
         folded = CHAR_ZERO;
         return KIND_SYMBOL;
      end
      if (up == CHAR_UP_I || up == CHAR_UP_L) begin
         folded = CHAR_ONE;
         return KIND_SYMBOL;
      end
      if (up >= CHAR_ZERO && up <= CHAR_NINE) return KIND_SYMBOL;
      if (up >= CHAR_UP_A && up <= CHAR_UP_Z && up != CHAR_UP_U) return KIND_SYMBOL;
      return KIND_REFUSE;
   endfunction

   // forget the current string
   task automatic clear_code();
      foreach (kept_symbols[i]) kept_symbols[i] = '0;
      kept_count = 0;
      refused    = 1'b0;
   endtask

   // advance the prediction by one accepted item
   task automatic absorb_byte(input logic [7:0] raw);
      kind_type        kind;
      logic [7:0]      folded;
      code_result_type res;
      kind = classify_byte(raw, folded);
      case (kind)
         KIND_TERM: begin
            res.accepted = !refused && kept_count == CODE_LENGTH;
            res.code     = '0;
            if (res.accepted) begin
               for (int i = 0; i < CODE_LENGTH; i++) begin
                  res.code = {res.code[CODE_W-SYMBOL_W-1:0], kept_symbols[i]};
               end
            end
            code_expect_q.push_back(res);
            clear_code();
         end
         KIND_REFUSE: begin
            refused = 1'b1;
         end
         KIND_SYMBOL: begin
            // a symbol past a full code refuses the string and is not kept
            if (!refused) begin
               if (kept_count >= CODE_LENGTH) begin
                  refused = 1'b1;
               end else begin
                  kept_symbols[kept_count] = folded;
                  kept_count++;
               end
            end
         end
         default: begin
         end
      endcase
   endtask

   // watch both channels at every edge
   always @(posedge clock) begin
      code_result_type want;
      if (reset) begin
         clear_code();
         code_expect_q.delete();
         fail_count = 0;
      end else begin
         // compare an outgoing item with the oldest prediction
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (code_expect_q.size() == 0) begin
               report_mismatch("unexpected result item", {63'd0, rsp_ch.accepted},
                               rsp_ch.code_symbols);
            end else begin
               want = code_expect_q.pop_front();
               if (rsp_ch.accepted !== want.accepted)
                  report_mismatch("accepted", {63'd0, rsp_ch.accepted},
                                  {63'd0, want.accepted});
               if (rsp_ch.code_symbols !== want.code)
                  report_mismatch("code_symbols", rsp_ch.code_symbols, want.code);
            end
         end
         // predict from an incoming item
         if (req_ch.valid && req_ch.ready) absorb_byte(req_ch.typed_byte);
      end
      pending_count <= code_expect_q.size();
   end

endmodule

FILE: sim/testbench.sv
// top of the base32 code normaliser testbench: clock, reset, stimulus and verdict
module testbench;
   import b32n_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 700;
   localparam int DRAIN_CYCLES = 12;

   logic clock = 1'b0;
   logic reset;
   int   check_fail_count;
   int   check_pending;
   int   items_sent;

   // idle pattern state of each side
   bit   req_calm;
   int   req_calm_left;
   bit   rsp_calm;
   int   rsp_calm_left;

   b32n_req_if req_if ();
   b32n_rsp_if rsp_if ();

   base32_code_normaliser_top u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   b32n_code_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_if),
      .rsp_ch        (rsp_if),
      .fail_count    (check_fail_count),
      .pending_count (check_pending)
   );

   always #10 clock = ~clock;

   // wait before one item, with calm stretches that never idle
   function automatic int draw_wait(inout bit calm, inout int calm_left);
      if (calm_left == 0) begin
         calm      = ($urandom_range(0, 3) == 0);
         calm_left = $urandom_range(10, 60);
      end
      calm_left--;
      return calm ? 0 : $urandom_range(0, 8);
   endfunction

   // offer one typed byte and hold it until taken
   task automatic send_byte(input logic [7:0] value);
      int gap;
      gap = draw_wait(req_calm, req_calm_left);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.typed_byte <= value;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_seq(input logic [7:0] seq [$]);
      foreach (seq[i]) send_byte(seq[i]);
   endtask

   // one alphabet symbol, its aliases included, in either case
   function automatic logic [7:0] pick_symbol();
      int         r;
      logic [7:0] c;
      r = $urandom_range(0, 35);
      c = (r < 10) ? CHAR_ZERO + 8'(r) : CHAR_UP_A + 8'(r - 10);
      if (c == CHAR_UP_U) c = CHAR_UP_Z;
      if (c >= CHAR_UP_A && $urandom_range(0, 1) == 1) c = c + CASE_OFFSET;
      return c;
   endfunction

   function automatic logic [7:0] pick_separator();
      case ($urandom_range(0, 4))
         0:       return CHAR_DASH;
         1:       return CHAR_SPACE;
         2:       return CHAR_TAB;
         3:       return CHAR_CR;
         default: return CHAR_LF;
      endcase
   endfunction

   // one random string: mostly well formed codes, some short, long or broken ones
   task automatic send_random_string();
      int         shape;
      int         n_sym;
      int         bad_at;
      logic [7:0] bad_byte;
      shape    = $urandom_range(0, 9);
      n_sym    = 8;
      bad_at   = -1;
      bad_byte = CHAR_UP_U;
      case (shape)
         6: n_sym = $urandom_range(0, 12);
         7: begin
            bad_at   = $urandom_range(0, 8);
            bad_byte = 8'($urandom_range(1, 255));
         end
         8: begin
            n_sym  = 0;
            bad_at = 0;
         end
         9: begin
            bad_at   = $urandom_range(0, 8);
            bad_byte = $urandom_range(0, 1) ? CHAR_UP_U : CHAR_UP_U + CASE_OFFSET;
         end
         default: begin
         end
      endcase
      if (shape == 8) begin
         // pure noise
         repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(1, 255)));
      end else begin
         for (int i = 0; i <= n_sym; i++) begin
            if (i == bad_at) send_byte(bad_byte);
            if (i < n_sym) begin
               if ($urandom_range(0, 3) == 0) send_byte(pick_separator());
               send_byte(pick_symbol());
            end
         end
      end
      send_byte(CHAR_NUL);
   endtask

   // result side may stall before each item
   initial begin
      int stall;
      rsp_if.ready <= 1'b0;
      forever begin
         stall = draw_wait(rsp_calm, rsp_calm_left);
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_if.valid) @(posedge clock);
      end
   end

   // stimulus and verdict
   initial begin
      reset             <= 1'b1;
      req_if.valid      <= 1'b0;
      req_if.typed_byte <= CHAR_NUL;
      items_sent = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // full code with aliases, both cases and every separator
      send_seq('{CHAR_ZERO, "o", "I", "l", CHAR_DASH, "Z", "z", CHAR_NINE, CHAR_CR,
                 CHAR_LF, CHAR_SPACE, "a", CHAR_TAB, CHAR_NUL});
      // empty string
      send_byte(CHAR_NUL);
      // lower case u refuses
      send_seq('{"u", CHAR_NUL});
      // top byte refuses, bytes after a refusal are ignored
      send_seq('{8'hFF, 8'h80, CHAR_NUL});
      // one symbol too many
      send_seq('{"A", "B", "C", "D", "E", "F", "G", "H", "J", CHAR_NUL});

      items_sent = 0;
      while (items_sent < RANDOM_ITEMS) send_random_string();

      req_if.valid <= 1'b0;
      @(posedge clock);
      while (check_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (check_fail_count == 0 && check_pending == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // hard limit on the run
   initial begin
      #2_000_000;
      $display("timeout waiting for the normaliser");
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
